// File: rtl/sgi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sgi_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int DIV_STEPS      = 33;
  localparam int OUT_BITS       = 32;

  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_PROPER   = 2'd1,
    KIND_VERTEX   = 2'd2,
    KIND_PARALLEL = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PL_BELOW = 2'd0,
    PL_IN    = 2'd1,
    PL_ABOVE = 2'd2,
    PL_END   = 2'd3
  } place_t;

  // Control that travels beside the data through the divider cells.
  typedef struct packed {
    logic  valid;
    kind_t kind;
    logic  negx;
    logic  negy;
    logic  clipx;
    logic  clipy;
  } ctl_t;

endpackage
`default_nettype wire

// File: rtl/segment_intersection_top.sv
// Pipeline from an accepted input word to its result word:
// 4 front stages for products, classification and point numerators, 33 divider cells,
// 1 output stage.
// Throughput: one segment pair per cycle; the whole pipeline advances when the
// output register is empty or being taken, so s_tready follows that condition.
// Reset (rst, synchronous, active high) clears every stage valid; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module segment_intersection_top #(
  parameter int COORD_BITS = sgi_pkg::COORD_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    s_tvalid,
  output logic                         s_tready,
  input  wire logic [8*COORD_BITS-1:0] s_tdata,  // ax, ay, bx, by_coord, cx, cy, dx, dy
  output logic                         m_tvalid,
  input  wire logic                    m_tready,
  output logic [71:0]                  m_tdata,  // px, py, clipped, zero fill
  output logic [1:0]                   m_tuser   // kind
);

  localparam int DW = 2 * COORD_BITS + 4;
  localparam int NW = 3 * COORD_BITS + 7;
  localparam int NS = sgi_pkg::DIV_STEPS;

  logic en;

  sgi_pkg::ctl_t       ctl [NS+1];
  logic [NW-1:0]       rx  [NS+1];
  logic [NW-1:0]       ry  [NS+1];
  logic [DW-1:0]       den [NS+1];
  logic [NS-1:0]       qx  [NS+1];
  logic [NS-1:0]       qy  [NS+1];

  logic [31:0] px_c, py_c;
  logic        cx_c, cy_c;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  sgi_front #(.CB(COORD_BITS), .DW(DW), .NW(NW)) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_tvalid),
    .in_data  (s_tdata),
    .ctl      (ctl[0]),
    .rx       (rx[0]),
    .ry       (ry[0]),
    .den      (den[0])
  );

  assign qx[0] = '0;
  assign qy[0] = '0;

  // Cell k settles quotient bit NS-1-k, most significant first.
  for (genvar k = 0; k < NS; k++) begin : g_cell
    sgi_div_cell #(.NW(NW), .DW(DW), .SHIFT(NS - 1 - k)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .ctl_in  (ctl[k]),
      .rx_in   (rx[k]),
      .ry_in   (ry[k]),
      .den_in  (den[k]),
      .qx_in   (qx[k]),
      .qy_in   (qy[k]),
      .ctl_out (ctl[k+1]),
      .rx_out  (rx[k+1]),
      .ry_out  (ry[k+1]),
      .den_out (den[k+1]),
      .qx_out  (qx[k+1]),
      .qy_out  (qy[k+1])
    );
  end

  always_comb begin
    cx_c = 1'b0;
    cy_c = 1'b0;
    if (!ctl[NS].negx) begin
      if (qx[NS] > NS'(32'h7fffffff)) begin
        cx_c = 1'b1;
        px_c = 32'h7fffffff;
      end else begin
        px_c = qx[NS][31:0];
      end
    end else begin
      if (qx[NS] > NS'(32'h80000000)) begin
        cx_c = 1'b1;
        px_c = 32'h80000000;
      end else begin
        px_c = 32'(-qx[NS]);
      end
    end
    if (!ctl[NS].negy) begin
      if (qy[NS] > NS'(32'h7fffffff)) begin
        cy_c = 1'b1;
        py_c = 32'h7fffffff;
      end else begin
        py_c = qy[NS][31:0];
      end
    end else begin
      if (qy[NS] > NS'(32'h80000000)) begin
        cy_c = 1'b1;
        py_c = 32'h80000000;
      end else begin
        py_c = 32'(-qy[NS]);
      end
    end
    // A value already past the quotient range saturates on its own sign.
    if (ctl[NS].clipx) begin
      px_c = ctl[NS].negx ? 32'h80000000 : 32'h7fffffff;
      cx_c = 1'b1;
    end
    if (ctl[NS].clipy) begin
      py_c = ctl[NS].negy ? 32'h80000000 : 32'h7fffffff;
      cy_c = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= ctl[NS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tuser <= ctl[NS].kind;
      if (ctl[NS].kind == sgi_pkg::KIND_PARALLEL) begin
        m_tdata <= '0;
      end else begin
        m_tdata <= {7'd0, cx_c | cy_c, py_c, px_c};
      end
    end
  end

  a_ready : assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output stage");

  a_parallel : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == sgi_pkg::KIND_PARALLEL |-> m_tdata == '0)
    else $error("parallel result carries a point");

  a_clip : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[64] |->
      (m_tdata[31:0] == 32'h7fffffff || m_tdata[31:0] == 32'h80000000 ||
       m_tdata[63:32] == 32'h7fffffff || m_tdata[63:32] == 32'h80000000))
    else $error("clipped flag without a saturated coordinate");

endmodule
`default_nettype wire

// File: rtl/sgi_front.sv
`timescale 1ns / 1ps
`default_nettype none
module sgi_front #(
  parameter int CB = sgi_pkg::COORD_BITS_DEF,
  parameter int DW = 2 * CB + 4,
  parameter int NW = 3 * CB + 7
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire logic [8*CB-1:0]      in_data,
  output sgi_pkg::ctl_t             ctl,
  output logic [NW-1:0]             rx,
  output logic [NW-1:0]             ry,
  output logic [DW-1:0]             den
);

  localparam int PW = 2 * CB + 2;
  localparam int CW = NW + sgi_pkg::DIV_STEPS + 1;

  logic                 v0, v1, v2;
  logic signed [CB-1:0] ax, ay, bx, by, cx, cy, dx, dy;

  logic signed [DW-1:0] den1, ns1, nt1;
  logic signed [CB-1:0] ax1, ay1;
  logic signed [CB:0]   bax1, bay1;

  logic signed [CB:0]   s_ab_x, s_dc_y, s_dc_x, s_ba_y, s_ad_y, s_ca_y, s_cb_y, s_ac_y;
  logic signed [PW-1:0] p0, p1, p2, p3, p4, p5, p6, p7;
  logic signed [DW-1:0] den_c, ns_c, nt_c;

  logic signed [DW-1:0] denp, nsp, ntp, dns, dnt;
  logic signed [NW-1:0] nx, ny;
  logic [NW-1:0]        mx, my;
  sgi_pkg::place_t      ps, pt;
  sgi_pkg::kind_t       kind_c;

  sgi_pkg::kind_t       kind2;
  logic signed [NW-1:0] nx2, ny2;
  logic signed [DW-1:0] denp2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax <= in_data[0*CB +: CB];
      ay <= in_data[1*CB +: CB];
      bx <= in_data[2*CB +: CB];
      by <= in_data[3*CB +: CB];
      cx <= in_data[4*CB +: CB];
      cy <= in_data[5*CB +: CB];
      dx <= in_data[6*CB +: CB];
      dy <= in_data[7*CB +: CB];
    end
  end

  always_comb begin
    s_ab_x = (CB+1)'(ax) - (CB+1)'(bx);
    s_dc_y = (CB+1)'(dy) - (CB+1)'(cy);
    s_dc_x = (CB+1)'(dx) - (CB+1)'(cx);
    s_ba_y = (CB+1)'(by) - (CB+1)'(ay);
    s_ad_y = (CB+1)'(ay) - (CB+1)'(dy);
    s_ca_y = (CB+1)'(cy) - (CB+1)'(ay);
    s_cb_y = (CB+1)'(cy) - (CB+1)'(by);
    s_ac_y = (CB+1)'(ay) - (CB+1)'(cy);
    p0 = PW'(s_ab_x) * PW'(s_dc_y);
    p1 = PW'(s_dc_x) * PW'(s_ba_y);
    p2 = PW'(ax) * PW'(s_dc_y);
    p3 = PW'(cx) * PW'(s_ad_y);
    p4 = PW'(dx) * PW'(s_ca_y);
    p5 = PW'(ax) * PW'(s_cb_y);
    p6 = PW'(bx) * PW'(s_ac_y);
    p7 = PW'(cx) * PW'(s_ba_y);
    den_c = DW'(p0) + DW'(p1);
    ns_c  = DW'(p2) + DW'(p3) + DW'(p4);
    nt_c  = -(DW'(p5) + DW'(p6) + DW'(p7));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den1 <= den_c;
      ns1  <= ns_c;
      nt1  <= nt_c;
      ax1  <= ax;
      ay1  <= ay;
      bax1 <= (CB+1)'(bx) - (CB+1)'(ax);
      bay1 <= (CB+1)'(by) - (CB+1)'(ay);
    end
  end

  // Flip all three so the denominator is positive before any compare.
  always_comb begin
    denp = den1[DW-1] ? -den1 : den1;
    nsp  = den1[DW-1] ? -ns1  : ns1;
    ntp  = den1[DW-1] ? -nt1  : nt1;
    dns  = nsp - denp;
    dnt  = ntp - denp;
    if (nsp == '0 || dns == '0)  ps = sgi_pkg::PL_END;
    else if (nsp[DW-1])          ps = sgi_pkg::PL_BELOW;
    else if (!dns[DW-1])         ps = sgi_pkg::PL_ABOVE;
    else                         ps = sgi_pkg::PL_IN;
    if (ntp == '0 || dnt == '0)  pt = sgi_pkg::PL_END;
    else if (ntp[DW-1])          pt = sgi_pkg::PL_BELOW;
    else if (!dnt[DW-1])         pt = sgi_pkg::PL_ABOVE;
    else                         pt = sgi_pkg::PL_IN;
    kind_c = sgi_pkg::KIND_NONE;
    if (ps == sgi_pkg::PL_END || pt == sgi_pkg::PL_END) kind_c = sgi_pkg::KIND_VERTEX;
    if (ps == sgi_pkg::PL_IN && pt == sgi_pkg::PL_IN) kind_c = sgi_pkg::KIND_PROPER;
    else if ((ps == sgi_pkg::PL_BELOW || ps == sgi_pkg::PL_ABOVE) &&
             (pt == sgi_pkg::PL_BELOW || pt == sgi_pkg::PL_ABOVE))
      kind_c = sgi_pkg::KIND_NONE;
    if (den1 == '0) kind_c = sgi_pkg::KIND_PARALLEL;
    nx = NW'(ax1) * NW'(denp) + NW'(nsp) * NW'(bax1);
    ny = NW'(ay1) * NW'(denp) + NW'(nsp) * NW'(bay1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind2 <= kind_c;
      nx2   <= nx;
      ny2   <= ny;
      denp2 <= denp;
    end
  end

  always_comb begin
    mx = nx2[NW-1] ? NW'(-nx2) : NW'(nx2);
    my = ny2[NW-1] ? NW'(-ny2) : NW'(ny2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (en) begin
      ctl.valid <= v2;
    end
    if (en) begin
      ctl.kind  <= kind2;
      ctl.negx  <= nx2[NW-1];
      ctl.negy  <= ny2[NW-1];
      ctl.clipx <= CW'(mx) >= (CW'(denp2) << sgi_pkg::DIV_STEPS);
      ctl.clipy <= CW'(my) >= (CW'(denp2) << sgi_pkg::DIV_STEPS);
      rx  <= mx;
      ry  <= my;
      den <= DW'(denp2);
    end
  end

endmodule
`default_nettype wire

// File: rtl/sgi_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module sgi_div_cell #(
  parameter int NW    = 55,
  parameter int DW    = 36,
  parameter int SHIFT = 0
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             en,
  input  sgi_pkg::ctl_t                         ctl_in,
  input  wire logic [NW-1:0]                    rx_in,
  input  wire logic [NW-1:0]                    ry_in,
  input  wire logic [DW-1:0]                    den_in,
  input  wire logic [sgi_pkg::DIV_STEPS-1:0]    qx_in,
  input  wire logic [sgi_pkg::DIV_STEPS-1:0]    qy_in,
  output sgi_pkg::ctl_t                         ctl_out,
  output logic [NW-1:0]                         rx_out,
  output logic [NW-1:0]                         ry_out,
  output logic [DW-1:0]                         den_out,
  output logic [sgi_pkg::DIV_STEPS-1:0]         qx_out,
  output logic [sgi_pkg::DIV_STEPS-1:0]         qy_out
);

  localparam int CW = NW + sgi_pkg::DIV_STEPS + 1;

  logic [CW-1:0] dsh;
  logic          gx, gy;
  logic [sgi_pkg::DIV_STEPS-1:0] qx_next, qy_next;

  always_comb begin
    dsh = CW'(den_in) << SHIFT;
    gx  = CW'(rx_in) >= dsh;
    gy  = CW'(ry_in) >= dsh;
    qx_next = qx_in;
    qy_next = qy_in;
    qx_next[SHIFT] = gx;
    qy_next[SHIFT] = gy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (en) begin
      ctl_out.valid <= ctl_in.valid;
    end
    if (en) begin
      ctl_out.kind  <= ctl_in.kind;
      ctl_out.negx  <= ctl_in.negx;
      ctl_out.negy  <= ctl_in.negy;
      ctl_out.clipx <= ctl_in.clipx;
      ctl_out.clipy <= ctl_in.clipy;
      den_out       <= den_in;
      rx_out        <= gx ? NW'(CW'(rx_in) - dsh) : rx_in;
      ry_out        <= gy ? NW'(CW'(ry_in) - dsh) : ry_in;
      qx_out        <= qx_next;
      qy_out        <= qy_next;
    end
  end

endmodule
`default_nettype wire
